FILE: design/qph_pkg.sv
// Shared types and constants for the quadratic-probe hash lookup core.
// Used by qph_mod and quadratic_probe_hash_lookup_core; no dependencies.
package qph_pkg;

  localparam int unsigned KEY_W   = 32;
  localparam int unsigned SLOT_W  = 10;
  localparam int unsigned SIZE_W  = 11;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  localparam logic [KEY_W-1:0] EMPTY_KEY = '0;

  typedef struct packed {
    logic              start;
    logic [KEY_W-1:0]  dividend;
    logic [SIZE_W-1:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic              done;
    logic [SIZE_W-1:0] remainder;
  } mod_rsp_t;

endpackage

FILE: design/qph_mod.sv
// Bit-serial unsigned remainder: 32-bit dividend modulo an 11-bit divisor.
// One quotient bit per cycle; done pulses once the last bit is in. Uses qph_pkg.
module qph_mod (
  input  logic              clk,
  input  logic              rst,
  input  qph_pkg::mod_req_t req,
  output qph_pkg::mod_rsp_t rsp
);

  localparam int unsigned CNT_W = $clog2(qph_pkg::KEY_W);

  logic                        busy;
  logic [CNT_W-1:0]            cnt;
  logic [qph_pkg::KEY_W-1:0]   dvd;
  logic [qph_pkg::SIZE_W-1:0]  dvs;
  logic [qph_pkg::SIZE_W-1:0]  rem;
  logic [qph_pkg::SIZE_W:0]    trial;
  logic [qph_pkg::SIZE_W-1:0]  rem_next;
  logic                        done;

  always_comb begin
    trial = {rem, dvd[qph_pkg::KEY_W-1]};
    if (trial >= {1'b0, dvs}) begin
      rem_next = qph_pkg::SIZE_W'(trial - {1'b0, dvs});
    end else begin
      rem_next = trial[qph_pkg::SIZE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        dvd  <= req.dividend;
        dvs  <= req.divisor;
        rem  <= '0;
      end else if (busy) begin
        rem <= rem_next;
        dvd <= {dvd[qph_pkg::KEY_W-2:0], 1'b0};
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(qph_pkg::KEY_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done      = done;
  assign rsp.remainder = rem;

endmodule

FILE: design/quadratic_probe_hash_lookup_core.sv
// Quadratic-probe hash lookup core: top level. Uses qph_pkg and qph_mod.
// Key store is one synchronous RAM of TABLE_DEPTH 32-bit entries.
//
// After reset the core clears every key store entry to the empty key and
// holds s_tready low meanwhile; cfg writes are taken at any time. A write
// transfer stores its key in the key store. A search first finds the
// home-slot remainder in qph_mod, then makes each probe as a RAM read and
// then a compare, and then posts the result; the core then returns to idle
// for the next transfer. With a zero table size a search skips the divider
// and the probes and posts a not-found result.
// One item is in flight at a time; the next transfer is taken while
// a result still waits in the output register, and a finished search then
// waits until that register is free.
module quadratic_probe_hash_lookup_core #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // slot[9:0], key[41:10], zero pad
  input  logic [0:0]  s_tuser,   // command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // match_slot[9:0], probe_count[19:10], zero pad
  output logic [0:0]  m_tuser,   // found
  input  logic        cfg_we,
  input  logic [10:0] cfg_wdata
);

  localparam int unsigned AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned SW  = qph_pkg::SLOT_W;
  localparam int unsigned ZW  = qph_pkg::SIZE_W;
  localparam int unsigned KW  = qph_pkg::KEY_W;
  localparam int unsigned CW  = ((AW > SW) ? AW : SW) + 1;
  localparam int unsigned MW  = ((AW + 1 > ZW) ? AW + 1 : ZW) + 1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_PROBE,
    S_CHECK,
    S_DONE
  } state_t;

  state_t                state;
  logic [AW-1:0]         clr_addr;
  logic [ZW-1:0]         table_size;
  logic [ZW-1:0]         m_size;
  logic [MW-1:0]         ts_ext;
  logic [ZW-1:0]         m_cur;
  logic [KW-1:0]         key;
  logic                  key_neg;
  logic [ZW-1:0]         idx;
  logic [ZW-1:0]         step;
  logic [ZW-1:0]         probe;
  logic                  res_found;
  logic [SW-1:0]         res_slot;
  logic [SW-1:0]         res_count;

  logic [KW-1:0]         mem [TABLE_DEPTH];
  logic [KW-1:0]         rdata;
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [KW-1:0]         mem_wdata;

  logic                  in_xfer;
  logic [SW-1:0]         in_slot;
  logic [KW-1:0]         in_key;
  logic                  slot_ok;

  qph_pkg::mod_req_t     mreq;
  qph_pkg::mod_rsp_t     mrsp;

  logic [ZW:0]           home_sum;
  logic [ZW-1:0]         home;
  logic [ZW:0]           idx_sum;
  logic [ZW-1:0]         idx_next;
  logic [ZW+1:0]         step_sum;
  logic [ZW+1:0]         step_red;
  logic [ZW-1:0]         step_next;

  assign in_slot = s_tdata[SW-1:0];
  assign in_key  = s_tdata[SW+KW-1:SW];
  assign in_xfer = s_tvalid && s_tready;
  assign s_tready = (state == S_IDLE);
  assign slot_ok = CW'(in_slot) < CW'(TABLE_DEPTH);

  assign ts_ext = MW'(table_size);
  assign m_size = (ts_ext > MW'(TABLE_DEPTH)) ? ZW'(TABLE_DEPTH) : table_size;

  // Key store write port: clearing pass or write command.
  always_comb begin
    if (state == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = qph_pkg::EMPTY_KEY;
    end else begin
      mem_we    = in_xfer && (s_tuser[0] == qph_pkg::CMD_WRITE) && slot_ok;
      mem_waddr = AW'(in_slot);
      mem_wdata = in_key;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[AW'(idx)];
  end

  assign mreq.start    = in_xfer && (s_tuser[0] == qph_pkg::CMD_SEARCH) && (m_size != '0);
  assign mreq.dividend = in_key[KW-1] ? (KW'(0) - in_key) : in_key;
  assign mreq.divisor  = m_size;

  qph_mod u_mod (
    .clk (clk),
    .rst (rst),
    .req (mreq),
    .rsp (mrsp)
  );

  // Home slot: fold the magnitude remainder back for negative keys.
  always_comb begin
    if (key_neg && (mrsp.remainder != '0)) begin
      home_sum = {1'b0, m_cur} - {1'b0, mrsp.remainder};
    end else begin
      home_sum = {1'b0, mrsp.remainder};
    end
    home = home_sum[ZW-1:0];
  end

  // Next probe: idx += step (2i+1 mod M), step += 2 mod M.
  always_comb begin
    idx_sum = {1'b0, idx} + {1'b0, step};
    if (idx_sum >= {1'b0, m_cur}) begin
      idx_sum = idx_sum - {1'b0, m_cur};
    end
    idx_next = idx_sum[ZW-1:0];
    step_sum = {2'b00, step} + (ZW+2)'(2);
    step_red = step_sum;
    if (step_red >= {2'b00, m_cur}) begin
      step_red = step_red - {2'b00, m_cur};
    end
    if (step_red >= {2'b00, m_cur}) begin
      step_red = step_red - {2'b00, m_cur};
    end
    step_next = step_red[ZW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      table_size <= ZW'(1024);
      m_tvalid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        table_size <= cfg_wdata;
      end
      if (m_tvalid && m_tready && (state != S_DONE)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(TABLE_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_xfer && (s_tuser[0] == qph_pkg::CMD_SEARCH)) begin
            key       <= in_key;
            key_neg   <= in_key[KW-1];
            m_cur     <= m_size;
            res_found <= 1'b0;
            res_slot  <= '0;
            res_count <= '0;
            if (m_size == '0) begin
              state <= S_DONE;
            end else begin
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (mrsp.done) begin
            idx   <= home;
            step  <= (m_cur == ZW'(1)) ? '0 : ZW'(1);
            probe <= '0;
            state <= S_PROBE;
          end
        end
        S_PROBE: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (rdata == key) begin
            res_found <= 1'b1;
            res_slot  <= idx[SW-1:0];
            res_count <= probe[SW-1:0];
            state     <= S_DONE;
          end else if (rdata == qph_pkg::EMPTY_KEY) begin
            state <= S_DONE;
          end else if (probe == m_cur - 1'b1) begin
            state <= S_DONE;
          end else begin
            probe <= probe + 1'b1;
            idx   <= idx_next;
            step  <= step_next;
            state <= S_PROBE;
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tuser  <= res_found;
            m_tdata  <= {4'b0000, res_count, res_slot};
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
